@@ src/base64_utf16_decoder_core_macros.svh @@
// assertion macros for the base64 utf-16 decoder core
// no dependencies; included by the modules that carry assertions
`ifndef BASE64_UTF16_DECODER_CORE_MACROS_SVH
`define BASE64_UTF16_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define B64U_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);
// condition must never be true outside reset
`define B64U_NEVER(lbl, clk, rst_n, cond, msg) \
	`B64U_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define B64U_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64U_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ src/b64u_pkg.sv @@
// types, codes and constants shared by the base64 utf-16 decoder core
// no dependencies
package b64u_pkg;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 4;

	localparam logic [7:0]  MIN_SYMBOLS_RST = 8'd8;
	localparam logic [15:0] UNIT_LIMIT_RST  = 16'd1023;

	localparam logic [5:0] LOWER_BASE = 6'd26;
	localparam logic [5:0] DIGIT_BASE = 6'd52;
	localparam logic [5:0] PLUS_CODE  = 6'd62;
	localparam logic [5:0] SLASH_CODE = 6'd63;
	localparam logic [7:0] COUNT_MAX  = 8'd255;

	// configuration register indexes
	typedef enum logic {
		REG_MIN_SYMBOLS = 1'b0,
		REG_UNIT_LIMIT  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_SKIP,
		K_DATA,
		K_PAD,
		K_BAD
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_CHAR,
		ST_TOO_FEW,
		ST_NO_UNITS,
		ST_TOO_MANY
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sextet;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic        unit_present;
		logic [15:0] decoded_unit;
		logic        end_of_text;
		status_t     status;
	} res_t;

endpackage

@@ src/b64u_queue.sv @@
// small register queue, up to two items pushed and one popped per cycle
// depends on base64_utf16_decoder_core_macros.svh
`include "base64_utf16_decoder_core_macros.svh"

module b64u_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  logic [WIDTH-1:0]           wdata0,
	input  logic [WIDTH-1:0]           wdata1,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [1:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(n);
		if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
		return s[PW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= wdata0;
		if (push_cnt == 2'd2) mem_q[wrap_add(wr_ptr_q, 2'd1)] <= wdata1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wrap_add(wr_ptr_q, push_cnt);
			rd_ptr_q <= wrap_add(rd_ptr_q, {1'b0, pop});
			count_q  <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

	`B64U_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "queue count beyond depth")
	`B64U_ASSERT(a_no_overflow, clk, arst_n, (CW+1)'(count_q) + (CW+1)'(push_cnt) <= (CW+1)'(DEPTH), "queue overflow")
	`B64U_NEVER(a_no_underflow, clk, arst_n, pop && count_q == '0, "pop from empty queue")
	`B64U_ASSERT(a_pop_only, clk, arst_n, (pop && push_cnt == 2'd0) |=> count_q == $past(count_q) - CW'(1), "count not tracking pop")

endmodule

@@ src/b64u_front.sv @@
// front part: classifies each character and queues it for the decoder
// depends on b64u_pkg and b64u_queue
module b64u_front #(
	parameter int CMD_DEPTH = b64u_pkg::CMD_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [15:0]   symbol,
	input  logic          final_symbol,
	output logic          full,
	output logic          cmd_valid,
	output b64u_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import b64u_pkg::*;

	localparam int CW = $clog2(CMD_DEPTH+1);

	cmd_t          cls;
	logic          take;
	logic [CW-1:0] cmd_count;

	always_comb begin
		cls.kind   = K_BAD;
		cls.sextet = '0;
		cls.last   = final_symbol;
		if (symbol >= 16'h0041 && symbol <= 16'h005A) begin
			cls.kind   = K_DATA;
			cls.sextet = 6'(symbol - 16'h0041);
		end else if (symbol >= 16'h0061 && symbol <= 16'h007A) begin
			cls.kind   = K_DATA;
			cls.sextet = 6'(symbol - 16'h0061) + LOWER_BASE;
		end else if (symbol >= 16'h0030 && symbol <= 16'h0039) begin
			cls.kind   = K_DATA;
			cls.sextet = 6'(symbol - 16'h0030) + DIGIT_BASE;
		end else if (symbol == 16'h002B) begin
			cls.kind   = K_DATA;
			cls.sextet = PLUS_CODE;
		end else if (symbol == 16'h002F) begin
			cls.kind   = K_DATA;
			cls.sextet = SLASH_CODE;
		end else if (symbol == 16'h003D) begin
			cls.kind = K_PAD;
		end else if (symbol == 16'h0020 || symbol == 16'h0009 ||
		             symbol == 16'h000D || symbol == 16'h000A) begin
			cls.kind = K_SKIP;
		end
	end

	assign full = (cmd_count == CW'(CMD_DEPTH));
	assign take = push && !full;
	assign cmd_valid = (cmd_count != '0);

	b64u_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt ({1'b0, take}),
		.wdata0   (cls),
		.wdata1   (cls),
		.pop      (cmd_pop),
		.rdata    (cmd),
		.count    (cmd_count)
	);

endmodule

@@ src/b64u_back.sv @@
// back part: group assembly, byte pairing, limits, status and result queue
// depends on b64u_pkg and b64u_queue
module b64u_back #(
	parameter int RES_DEPTH = b64u_pkg::RES_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  b64u_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           cfg_we,
	input  logic           cfg_addr,
	input  logic [15:0]    cfg_wdata,
	input  logic           pop,
	output logic           empty,
	output b64u_pkg::res_t head
);
	import b64u_pkg::*;

	localparam int CW = $clog2(RES_DEPTH+1);
	localparam logic [CW-1:0] RoomMax = CW'(RES_DEPTH - 2);

	logic [7:0]  min_q;
	logic [15:0] limit_q;

	logic [17:0] group_q, n_group;
	logic [1:0]  fill_q, n_fill;
	logic        pdone_q, n_pdone;
	logic [7:0]  hb_q, n_hb;
	logic        hv_q, n_hv;
	logic [7:0]  dcnt_q, n_dcnt;
	logic [15:0] ucnt_q, n_ucnt;
	status_t     err_q, n_err;

	logic          go;
	logic [1:0]    nbytes, nout;
	logic [7:0]    bytes_v [3];
	logic [15:0]   units [2];
	logic [23:0]   word;
	status_t       st;
	res_t          r0, r1;
	logic [1:0]    push_cnt;
	logic [CW-1:0] res_count;

	assign go      = cmd_valid && (res_count <= RoomMax);
	assign cmd_pop = go;

	always_comb begin
		n_group = group_q;
		n_fill  = fill_q;
		n_pdone = pdone_q;
		n_hb    = hb_q;
		n_hv    = hv_q;
		n_dcnt  = dcnt_q;
		n_ucnt  = ucnt_q;
		n_err   = err_q;
		nbytes  = '0;
		nout    = '0;
		bytes_v = '{default: '0};
		units   = '{default: '0};
		word    = {group_q, cmd.sextet};
		st      = ST_OK;

		// after padding or a bad character the rest of the text is ignored
		if (err_q != ST_BAD_CHAR && !pdone_q) begin
			unique case (cmd.kind)
				K_DATA: begin
					if (dcnt_q != COUNT_MAX) n_dcnt = dcnt_q + 8'd1;
					if (fill_q == 2'd3) begin
						bytes_v[0] = word[23:16];
						bytes_v[1] = word[15:8];
						bytes_v[2] = word[7:0];
						nbytes     = 2'd3;
						n_group    = '0;
						n_fill     = '0;
					end else begin
						n_group = {group_q[11:0], cmd.sextet};
						n_fill  = fill_q + 2'd1;
					end
				end
				K_PAD: begin
					if (fill_q == 2'd2) begin
						bytes_v[0] = group_q[11:4];
						nbytes     = 2'd1;
					end else if (fill_q == 2'd3) begin
						bytes_v[0] = group_q[17:10];
						bytes_v[1] = group_q[9:2];
						nbytes     = 2'd2;
					end
					n_pdone = 1'b1;
				end
				K_BAD:  n_err = ST_BAD_CHAR;
				K_SKIP: ;
				default: ;
			endcase
		end

		// pair bytes low first; units past the limit are withheld
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < nbytes) begin
				if (!n_hv) begin
					n_hb = bytes_v[i];
					n_hv = 1'b1;
				end else begin
					n_hv = 1'b0;
					if (n_err == ST_TOO_MANY || n_ucnt >= limit_q) begin
						n_err = ST_TOO_MANY;
					end else begin
						n_ucnt          = n_ucnt + 16'd1;
						units[nout[0]]  = {bytes_v[i], n_hb};
						nout            = nout + 2'd1;
					end
				end
			end
		end

		priority if (n_err == ST_BAD_CHAR)                   st = ST_BAD_CHAR;
		else if (n_dcnt < min_q)                             st = ST_TOO_FEW;
		else if (n_ucnt == '0 && n_err != ST_TOO_MANY)       st = ST_NO_UNITS;
		else if (n_err == ST_TOO_MANY)                       st = ST_TOO_MANY;
		else                                                 st = ST_OK;

		r0 = '{unit_present: nout != 2'd0, decoded_unit: units[0],
		       end_of_text: 1'b0, status: ST_OK};
		r1 = '{unit_present: 1'b1, decoded_unit: units[1],
		       end_of_text: 1'b0, status: ST_OK};

		if (cmd.last) begin
			if (nout == 2'd0) nout = 2'd1;
			if (nout == 2'd1) begin
				r0.end_of_text = 1'b1;
				r0.status      = st;
			end else begin
				r1.end_of_text = 1'b1;
				r1.status      = st;
			end
			n_group = '0;
			n_fill  = '0;
			n_pdone = 1'b0;
			n_hb    = '0;
			n_hv    = 1'b0;
			n_dcnt  = '0;
			n_ucnt  = '0;
			n_err   = ST_OK;
		end
	end

	assign push_cnt = go ? nout : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= MIN_SYMBOLS_RST;
			limit_q <= UNIT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_MIN_SYMBOLS: min_q   <= cfg_wdata[7:0];
				REG_UNIT_LIMIT:  limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			fill_q  <= '0;
			pdone_q <= 1'b0;
			hb_q    <= '0;
			hv_q    <= 1'b0;
			dcnt_q  <= '0;
			ucnt_q  <= '0;
			err_q   <= ST_OK;
		end else if (go) begin
			group_q <= n_group;
			fill_q  <= n_fill;
			pdone_q <= n_pdone;
			hb_q    <= n_hb;
			hv_q    <= n_hv;
			dcnt_q  <= n_dcnt;
			ucnt_q  <= n_ucnt;
			err_q   <= n_err;
		end
	end

	assign empty = (res_count == '0);

	b64u_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.wdata0   (r0),
		.wdata1   (r1),
		.pop      (pop && !empty),
		.rdata    (head),
		.count    (res_count)
	);

endmodule

@@ src/base64_utf16_decoder_core.sv @@
// base64 decoder for utf-16 text: one character per cycle in unless full; 16-bit units out
// a character is registered in the command queue, then its results in the result queue
// one character per cycle while the result queue has room; results leave one per cycle
// every character waits in the command queue until the result queue has room for two results
// reset: arst_n clears queues and text state and loads register defaults; no clearing pass
module base64_utf16_decoder_core #(
	parameter int CMD_DEPTH = b64u_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = b64u_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] symbol,
	input  logic        final_symbol,
	output logic        empty,
	input  logic        pop,
	output logic        unit_present,
	output logic [15:0] decoded_unit,
	output logic        end_of_text,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import b64u_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	res_t head;

	b64u_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.symbol       (symbol),
		.final_symbol (final_symbol),
		.full         (full),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	b64u_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign unit_present = head.unit_present;
	assign decoded_unit = head.decoded_unit;
	assign end_of_text  = head.end_of_text;
	assign status       = 3'(head.status);

endmodule

@@ test/base64_utf16_decoder_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for base64_utf16_decoder_core: queued texts, random handshakes,
// an in-bench decoder model and field-by-field result checks
// depends on b64u_pkg and the core under src
module base64_utf16_decoder_core_tb;
	import b64u_pkg::*;

	localparam int RUN_LIMIT   = 250000;
	localparam int DRAIN_LIMIT = 20000;

	localparam logic [15:0] CH_SP  = 16'h0020;
	localparam logic [15:0] CH_TAB = 16'h0009;
	localparam logic [15:0] CH_CR  = 16'h000D;
	localparam logic [15:0] CH_LF  = 16'h000A;
	localparam logic [15:0] CH_EQ  = 16'h003D;

	typedef struct packed {
		logic [15:0] sym;
		logic        fin;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] symbol = '0;
	logic        final_symbol = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        unit_present;
	logic [15:0] decoded_unit;
	logic        end_of_text;
	logic [2:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [15:0] cfg_wdata = '0;

	text_char_t chars_to_send[$];
	res_t       due_results[$];

	int cycles = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int chars_queued = 0;

	// decoder model: register copies and per-text state
	logic [7:0]  cfg_min_syms = MIN_SYMBOLS_RST;
	logic [15:0] cfg_unit_cap = UNIT_LIMIT_RST;
	logic [17:0] acc_sextets = '0;
	logic [1:0]  acc_fill = '0;
	logic        data_closed = 1'b0;
	logic [7:0]  half_unit = '0;
	logic        half_unit_ok = 1'b0;
	logic [7:0]  data_syms = '0;
	logic [15:0] units_sent = '0;
	status_t     text_err = ST_OK;

	base64_utf16_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.symbol       (symbol),
		.final_symbol (final_symbol),
		.empty        (empty),
		.pop          (pop),
		.unit_present (unit_present),
		.decoded_unit (decoded_unit),
		.end_of_text  (end_of_text),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	function automatic logic [6:0] decode_sextet(input logic [15:0] c);
		if (c >= 16'("A") && c <= 16'("Z")) return 7'(c - 16'("A"));
		if (c >= 16'("a") && c <= 16'("z")) return 7'(c - 16'("a")) + 7'(LOWER_BASE);
		if (c >= 16'("0") && c <= 16'("9")) return 7'(c - 16'("0")) + 7'(DIGIT_BASE);
		if (c == 16'("+")) return 7'(PLUS_CODE);
		if (c == 16'("/")) return 7'(SLASH_CODE);
		return 7'd64;
	endfunction

	// pairs bytes little-endian; units past the cap are held back
	task automatic pair_byte(input logic [7:0] b);
		res_t r;
		if (!half_unit_ok) begin
			half_unit = b;
			half_unit_ok = 1'b1;
		end else begin
			half_unit_ok = 1'b0;
			if (text_err == ST_TOO_MANY || units_sent >= cfg_unit_cap) begin
				text_err = ST_TOO_MANY;
			end else begin
				units_sent++;
				r.unit_present = 1'b1;
				r.decoded_unit = {b, half_unit};
				r.end_of_text = 1'b0;
				r.status = ST_OK;
				due_results.push_back(r);
			end
		end
	endtask

	task automatic decode_char(input text_char_t ch);
		logic [6:0]  v;
		logic [23:0] word;
		logic        ws;
		int          n_before;
		status_t     st;
		res_t        r;
		n_before = due_results.size();
		ws = (ch.sym == CH_SP || ch.sym == CH_TAB || ch.sym == CH_CR || ch.sym == CH_LF);
		if (text_err != ST_BAD_CHAR && !data_closed && !ws) begin
			if (ch.sym == CH_EQ) begin
				if (acc_fill == 2'd2) begin
					pair_byte(acc_sextets[11:4]);
				end else if (acc_fill == 2'd3) begin
					pair_byte(acc_sextets[17:10]);
					pair_byte(acc_sextets[9:2]);
				end
				data_closed = 1'b1;
			end else begin
				v = decode_sextet(ch.sym);
				if (v[6]) begin
					text_err = ST_BAD_CHAR;
				end else begin
					if (data_syms != COUNT_MAX) data_syms++;
					if (acc_fill == 2'd3) begin
						word = {acc_sextets, v[5:0]};
						pair_byte(word[23:16]);
						pair_byte(word[15:8]);
						pair_byte(word[7:0]);
						acc_sextets = '0;
						acc_fill = '0;
					end else begin
						acc_sextets = {acc_sextets[11:0], v[5:0]};
						acc_fill++;
					end
				end
			end
		end
		if (ch.fin) begin
			if (text_err == ST_BAD_CHAR) st = ST_BAD_CHAR;
			else if (data_syms < cfg_min_syms) st = ST_TOO_FEW;
			else if (units_sent == 0 && text_err != ST_TOO_MANY) st = ST_NO_UNITS;
			else if (text_err == ST_TOO_MANY) st = ST_TOO_MANY;
			else st = ST_OK;
			if (due_results.size() == n_before) begin
				r.unit_present = 1'b0;
				r.decoded_unit = '0;
			end else begin
				r = due_results.pop_back();
			end
			r.end_of_text = 1'b1;
			r.status = st;
			due_results.push_back(r);
			acc_sextets = '0;
			acc_fill = '0;
			data_closed = 1'b0;
			half_unit = '0;
			half_unit_ok = 1'b0;
			data_syms = '0;
			units_sent = '0;
			text_err = ST_OK;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: unit %h status %0d",
				decoded_unit, status));
		end else begin
			want = due_results.pop_front();
			if (unit_present !== want.unit_present)
				report_mismatch($sformatf("unit_present got %b want %b",
					unit_present, want.unit_present));
			if (decoded_unit !== want.decoded_unit)
				report_mismatch($sformatf("decoded_unit got %h want %h",
					decoded_unit, want.decoded_unit));
			if (end_of_text !== want.end_of_text)
				report_mismatch($sformatf("end_of_text got %b want %b",
					end_of_text, want.end_of_text));
			if (status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d", status, want.status));
		end
	endtask

	// sender: an item leaves the queue at the edge that accepts it
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) decode_char(chars_to_send.pop_front());
			if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				symbol <= chars_to_send[0].sym;
				final_symbol <= chars_to_send[0].fin;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) check_result();
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_char(input logic [15:0] sym, input logic fin);
		text_char_t c;
		c.sym = sym;
		c.fin = fin;
		chars_to_send.push_back(c);
		chars_queued++;
	endtask

	function automatic logic [15:0] alphabet_char(input int v);
		if (v < 26) return 16'("A" + v);
		if (v < 52) return 16'("a" + v - 26);
		if (v < 62) return 16'("0" + v - 52);
		if (v == 62) return 16'("+");
		return 16'("/");
	endfunction

	function automatic logic [15:0] blank_char();
		case ($urandom_range(3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// one text: mostly well-formed base64 with blanks, padding and tails; some pure noise
	task automatic queue_text(input int n_data);
		text_char_t t[$];
		text_char_t c;
		int bad_at;
		int k;
		c.fin = 1'b0;
		if ($urandom_range(9) == 0) begin
			k = $urandom_range(1, 6);
			repeat (k) begin
				c.sym = 16'($urandom);
				t.push_back(c);
			end
		end else begin
			bad_at = ($urandom_range(7) == 0) ? int'($urandom_range(n_data)) : -1;
			for (int i = 0; i < n_data; i++) begin
				if (i == bad_at) begin
					c.sym = 16'($urandom);
					t.push_back(c);
				end
				if ($urandom_range(9) == 0) begin
					c.sym = blank_char();
					t.push_back(c);
				end
				c.sym = alphabet_char($urandom_range(63));
				t.push_back(c);
			end
			if ($urandom_range(3) != 0) begin
				k = $urandom_range(1, 3);
				repeat (k) begin
					c.sym = CH_EQ;
					t.push_back(c);
				end
				// text after the padding must be ignored
				if ($urandom_range(1) == 1) begin
					k = $urandom_range(1, 4);
					repeat (k) begin
						c.sym = $urandom_range(1) ? 16'($urandom) : alphabet_char($urandom_range(63));
						t.push_back(c);
					end
				end
			end
			if ($urandom_range(4) == 0) begin
				c.sym = blank_char();
				t.push_back(c);
			end
		end
		if (t.size() == 0) begin
			c.sym = alphabet_char($urandom_range(63));
			t.push_back(c);
		end
		foreach (t[i]) queue_char(t[i].sym, i == t.size() - 1);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while ((chars_to_send.size() != 0 || due_results.size() != 0) && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (due_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", due_results.size()));
			due_results.delete();
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_SYMBOLS) cfg_min_syms = val[7:0];
		else cfg_unit_cap = val;
	endtask

	task automatic run_phase(input logic [7:0] min_syms, input logic [15:0] unit_cap,
			input int n_chars, input logic with_long, input int s_pct, input int r_pct);
		int start;
		drain();
		write_reg(REG_MIN_SYMBOLS, 16'(min_syms));
		write_reg(REG_UNIT_LIMIT, unit_cap);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = chars_queued;
		// a long text drives the data symbol count into saturation
		if (with_long) queue_text(270);
		while (chars_queued - start < n_chars) queue_text($urandom_range(24));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 59;

		// every alphabet class, blanks, padding at group start, ignored tail
		queue_char(16'("A"), 1'b0);
		queue_char(16'("z"), 1'b0);
		queue_char(16'("0"), 1'b0);
		queue_char(16'("+"), 1'b0);
		queue_char(16'("/"), 1'b0);
		queue_char(16'("9"), 1'b0);
		queue_char(CH_TAB, 1'b0);
		queue_char(16'("a"), 1'b0);
		queue_char(16'("Z"), 1'b0);
		queue_char(CH_EQ, 1'b0);
		queue_char(16'("!"), 1'b0);
		queue_char(16'hFFFF, 1'b1);
		// invalid character alone
		queue_char(16'h0000, 1'b1);
		// lone data symbol before padding, too few symbols
		queue_char(16'("Q"), 1'b0);
		queue_char(16'("U"), 1'b0);
		queue_char(16'("J"), 1'b0);
		queue_char(16'("D"), 1'b0);
		queue_char(16'("R"), 1'b0);
		queue_char(CH_CR, 1'b0);
		queue_char(CH_SP, 1'b0);
		queue_char(CH_LF, 1'b0);
		queue_char(CH_EQ, 1'b1);
		// partial group dropped at the end
		queue_char(16'("Q"), 1'b0);
		queue_char(16'("Q"), 1'b1);
		// padding as the whole text
		queue_char(CH_EQ, 1'b1);

		run_phase(8'd1, 16'd65535, 250, 1'b0, 18, 59);
		run_phase(8'd255, 16'd1, 120, 1'b1, 18, 59);
		run_phase(8'd3, 16'd5, 250, 1'b0, 59, 18);
		run_phase(8'd255, 16'd65535, 180, 1'b1, 59, 18);
		run_phase(MIN_SYMBOLS_RST, UNIT_LIMIT_RST, 400, 1'b0, 0, 0);
		drain();

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
